/* rtl/home_control_response_parser_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the response parser
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HOME_CONTROL_RESPONSE_PARSER_MACROS_SVH
`define HOME_CONTROL_RESPONSE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCRP_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcrp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HCRP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcrp assertion failed");

`endif

/* rtl/hcrp_pkg.sv */
// ----------------------------------------------------------------------------
// hcrp_pkg
// Types and constants shared by the response parser modules.
// ----------------------------------------------------------------------------
package hcrp_pkg;

	localparam int GRAPHICS_ENTRIES = 256;
	localparam int TIMER_ENTRIES    = 128;
	localparam int SYNC_MIN         = 6;
	localparam int EVENT_BYTES      = 8;
	localparam int HOUSE_SHIFT      = 4;
	localparam int ENTRY_W          = 9;

	localparam logic [7:0] SYNC_RESET = 8'hFF;

	// Input opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_ARM  = 1'b1;

	// Expectation codes; code 7 is legal on input and behaves like idle.
	localparam logic [2:0] EX_IDLE       = 3'd0;
	localparam logic [2:0] EX_ACK        = 3'd1;
	localparam logic [2:0] EX_ACK_UPLOAD = 3'd2;
	localparam logic [2:0] EX_CLOCK      = 3'd3;
	localparam logic [2:0] EX_UPLOAD     = 3'd4;
	localparam logic [2:0] EX_GRAPHICS   = 3'd5;
	localparam logic [2:0] EX_TIMER      = 3'd6;

	// Report kinds
	localparam logic [2:0] RK_NONE   = 3'd0;
	localparam logic [2:0] RK_MINUTE = 3'd1;
	localparam logic [2:0] RK_HOUR   = 3'd2;
	localparam logic [2:0] RK_DAY    = 3'd3;
	localparam logic [2:0] RK_HOUSE  = 3'd4;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_SYNC   = 4'd1,
		PH_STATUS = 4'd2,
		PH_SKIP1  = 4'd3,
		PH_SKIP2  = 4'd4,
		PH_SKIP3  = 4'd5,
		PH_LAST   = 4'd6,
		PH_MINUTE = 4'd7,
		PH_HOUR   = 4'd8,
		PH_DAY    = 4'd9,
		PH_ICON1  = 4'd10,
		PH_ICON2  = 4'd11,
		PH_EVENT1 = 4'd12,
		PH_EVENT8 = 4'd13
	} phase_t;

	// Classified item passed from the front end to the parser.
	typedef struct packed {
		logic       arm;
		logic       is_sync;
		logic [7:0] rx_byte;
		logic [2:0] kind;
	} item_t;

	// One result item.
	typedef struct packed {
		logic       status_valid;
		logic [7:0] status_value;
		logic [2:0] report_kind;
		logic [7:0] report_value;
		logic       command_complete;
	} result_t;

	// Queue handshake between front end and parser.
	typedef struct packed {
		logic valid;
		logic ready;
	} qhs_t;

endpackage

/* rtl/hcrp_front.sv */
// ----------------------------------------------------------------------------
// hcrp_front
// Accepts input items, holds the sync byte register and classifies each byte.
// ----------------------------------------------------------------------------
module hcrp_front import hcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte [7:0], expect_kind [10:8], zero pad
	input  logic        s_tuser,   // opcode
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,  // sync_byte
	input  logic        q_ready,
	output logic        q_valid,
	output item_t       q_item
);

	logic [7:0] sync_byte_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q <= SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sync_byte_q <= cfg_data;
		end
	end

	assign s_tready = q_ready;
	assign q_valid  = s_tvalid;

	always_comb begin
		q_item.arm     = (s_tuser == OP_ARM);
		q_item.rx_byte = s_tdata[7:0];
		q_item.kind    = s_tdata[10:8];
		q_item.is_sync = (s_tdata[7:0] == sync_byte_q);
	end

endmodule

/* rtl/hcrp_queue.sv */
// ----------------------------------------------------------------------------
// hcrp_queue
// Two-entry queue of classified items between the front end and the parser.
// ----------------------------------------------------------------------------
module hcrp_queue import hcrp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output qhs_t  pop_hs_o,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready     = (count_q != 2'd2);
	assign push           = push_valid && push_ready;
	assign pop_hs_o.valid = (count_q != 2'd0);
	assign pop_hs_o.ready = pop_ready;
	assign pop            = pop_hs_o.valid && pop_ready;
	assign pop_item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/hcrp_back.sv */
// ----------------------------------------------------------------------------
// hcrp_back
// Response parser state machine with a registered result output.
// ----------------------------------------------------------------------------
`include "home_control_response_parser_macros.svh"

module hcrp_back import hcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qhs_t        q_hs,
	output logic        q_ready,
	input  item_t       q_item,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // status_value [7:0], report_value [15:8]
	output logic [3:0]  m_tuser,   // status_valid [0], report_kind [3:1]
	output logic        m_tlast    // command_complete
);

	phase_t               phase_q, phase_d;
	logic [2:0]           exp_q, exp_d;
	logic [2:0]           sync_cnt_q, sync_cnt_d;
	logic [ENTRY_W-1:0]   entry_cnt_q, entry_cnt_d, entry_inc;
	logic [3:0]           ev_cnt_q, ev_cnt_d;
	result_t              res;
	result_t              out_q;
	logic                 out_valid_q;
	logic                 pop;
	logic                 sync_ok;

	assign q_ready  = !out_valid_q || m_tready;
	assign pop      = q_hs.valid && q_hs.ready;
	assign sync_ok  = (sync_cnt_q >= 3'(SYNC_MIN));
	assign entry_inc = (entry_cnt_q != '1) ? entry_cnt_q + 1'b1 : entry_cnt_q;

	// Next state
	always_comb begin
		phase_d     = phase_q;
		exp_d       = exp_q;
		sync_cnt_d  = sync_cnt_q;
		entry_cnt_d = entry_cnt_q;
		ev_cnt_d    = ev_cnt_q;
		if (q_item.arm) begin
			exp_d       = q_item.kind;
			phase_d     = PH_IDLE;
			sync_cnt_d  = '0;
			entry_cnt_d = '0;
			ev_cnt_d    = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (q_item.is_sync) begin
						phase_d    = PH_SYNC;
						sync_cnt_d = 3'd1;
					end
				end
				PH_SYNC: begin
					if (q_item.is_sync) begin
						if (sync_cnt_q != 3'd7) begin
							sync_cnt_d = sync_cnt_q + 3'd1;
						end
					end else if (sync_ok) begin
						sync_cnt_d = '0;
						if (exp_q == EX_ACK_UPLOAD) begin
							phase_d = PH_IDLE;
							exp_d   = EX_UPLOAD;
						end else if (exp_q == EX_CLOCK || exp_q == EX_UPLOAD) begin
							phase_d = PH_STATUS;
						end else if (exp_q == EX_GRAPHICS || exp_q == EX_TIMER) begin
							phase_d     = PH_STATUS;
							entry_cnt_d = '0;
						end else begin
							phase_d = PH_IDLE;
							exp_d   = EX_IDLE;
						end
					end else begin
						sync_cnt_d = '0;
						phase_d    = PH_IDLE;
					end
				end
				PH_STATUS: begin
					if (exp_q == EX_UPLOAD) begin
						phase_d = PH_SKIP1;
					end else if (exp_q == EX_CLOCK) begin
						phase_d = PH_MINUTE;
					end else if (exp_q == EX_GRAPHICS) begin
						if (q_item.is_sync) begin
							entry_cnt_d = entry_inc;
							phase_d     = PH_ICON2;
						end else begin
							phase_d = PH_ICON1;
						end
					end else if (exp_q == EX_TIMER) begin
						if (q_item.is_sync) begin
							entry_cnt_d = entry_inc;
							phase_d     = PH_EVENT8;
						end else begin
							ev_cnt_d = 4'd1;
							phase_d  = PH_EVENT1;
						end
					end else begin
						phase_d = PH_IDLE;
						exp_d   = EX_IDLE;
					end
				end
				PH_SKIP1, PH_SKIP2, PH_SKIP3: begin
					if (exp_q == EX_UPLOAD) begin
						phase_d = (phase_q == PH_SKIP1) ? PH_SKIP2 :
							(phase_q == PH_SKIP2) ? PH_SKIP3 : PH_LAST;
					end else begin
						phase_d = PH_IDLE;
						exp_d   = EX_IDLE;
					end
				end
				PH_MINUTE, PH_HOUR, PH_DAY: begin
					if (exp_q == EX_CLOCK) begin
						phase_d = (phase_q == PH_MINUTE) ? PH_HOUR :
							(phase_q == PH_HOUR) ? PH_DAY : PH_LAST;
					end else begin
						phase_d = PH_IDLE;
						exp_d   = EX_IDLE;
					end
				end
				PH_LAST: begin
					phase_d = PH_IDLE;
					exp_d   = EX_IDLE;
				end
				PH_ICON1: begin
					if (exp_q == EX_GRAPHICS) begin
						phase_d = PH_ICON2;
					end else begin
						phase_d = PH_IDLE;
						exp_d   = EX_IDLE;
					end
				end
				PH_ICON2: begin
					if (exp_q != EX_GRAPHICS) begin
						phase_d = PH_IDLE;
						exp_d   = EX_IDLE;
					end else if (entry_cnt_q >= ENTRY_W'(GRAPHICS_ENTRIES)) begin
						entry_cnt_d = '0;
						phase_d     = PH_IDLE;
						exp_d       = EX_IDLE;
					end else if (q_item.is_sync) begin
						entry_cnt_d = entry_inc;
					end else begin
						phase_d = PH_ICON1;
					end
				end
				PH_EVENT1: begin
					if (exp_q != EX_TIMER) begin
						phase_d = PH_IDLE;
						exp_d   = EX_IDLE;
					end else if (ev_cnt_q == 4'(EVENT_BYTES)) begin
						phase_d = PH_EVENT8;
					end else begin
						ev_cnt_d = ev_cnt_q + 4'd1;
					end
				end
				PH_EVENT8: begin
					if (exp_q != EX_TIMER) begin
						phase_d = PH_IDLE;
						exp_d   = EX_IDLE;
					end else if (entry_cnt_q >= ENTRY_W'(TIMER_ENTRIES)) begin
						entry_cnt_d = '0;
						phase_d     = PH_IDLE;
						exp_d       = EX_IDLE;
					end else if (q_item.is_sync) begin
						entry_cnt_d = entry_inc;
					end else begin
						ev_cnt_d = 4'd1;
						phase_d  = PH_EVENT1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result of the current item
	always_comb begin
		res = '0;
		if (!q_item.arm) begin
			unique case (phase_q)
				PH_SYNC: begin
					if (!q_item.is_sync && sync_ok) begin
						res.status_valid     = 1'b1;
						res.status_value     = q_item.rx_byte;
						res.command_complete = (exp_q == EX_ACK);
					end
				end
				PH_STATUS: begin
					if (exp_q == EX_CLOCK) begin
						res.report_kind  = RK_MINUTE;
						res.report_value = q_item.rx_byte;
					end
				end
				PH_MINUTE: begin
					if (exp_q == EX_CLOCK) begin
						res.report_kind  = RK_HOUR;
						res.report_value = q_item.rx_byte;
					end
				end
				PH_HOUR: begin
					if (exp_q == EX_CLOCK) begin
						res.report_kind  = RK_DAY;
						res.report_value = q_item.rx_byte;
					end
				end
				PH_SKIP3, PH_DAY: begin
					if ((phase_q == PH_SKIP3 && exp_q == EX_UPLOAD) ||
						(phase_q == PH_DAY && exp_q == EX_CLOCK)) begin
						res.report_kind  = RK_HOUSE;
						res.report_value = q_item.rx_byte >> HOUSE_SHIFT;
					end
				end
				PH_LAST: begin
					res.command_complete = (exp_q == EX_UPLOAD) || (exp_q == EX_CLOCK);
				end
				PH_ICON2: begin
					res.command_complete = (exp_q == EX_GRAPHICS) &&
						(entry_cnt_q >= ENTRY_W'(GRAPHICS_ENTRIES));
				end
				PH_EVENT8: begin
					res.command_complete = (exp_q == EX_TIMER) &&
						(entry_cnt_q >= ENTRY_W'(TIMER_ENTRIES));
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			exp_q       <= EX_IDLE;
			sync_cnt_q  <= '0;
			entry_cnt_q <= '0;
			ev_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				exp_q       <= exp_d;
				sync_cnt_q  <= sync_cnt_d;
				entry_cnt_q <= entry_cnt_d;
				ev_cnt_q    <= ev_cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.report_value, out_q.status_value};
	assign m_tuser  = {out_q.report_kind, out_q.status_valid};
	assign m_tlast  = out_q.command_complete;

	// A finished response always leaves the parser idle.
	`HCRP_ASSERT_NEXT(a_done_idles, pop && res.command_complete, phase_q == PH_IDLE)
	// Arming clears every counter.
	`HCRP_ASSERT_NEXT(a_arm_clears, pop && q_item.arm,
		sync_cnt_q == 3'd0 && entry_cnt_q == '0 && ev_cnt_q == 4'd0)
	// The status byte is only taken out of the sync phase.
	`HCRP_ASSERT_SAME(a_status_from_sync, res.status_valid, phase_q == PH_SYNC)
	// A status item never carries a report.
	`HCRP_ASSERT_SAME(a_status_no_report, res.status_valid, res.report_kind == RK_NONE)

endmodule

/* rtl/home_control_response_parser.sv */
// ----------------------------------------------------------------------------
// home_control_response_parser
// Parser for response bytes from a powerline home-control interface.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless m_tready stalls the output, and gives
// exactly one result item for each. A classifying front end feeds a two-entry
// queue; the parser state machine updates its state once per item and writes
// a result register. An item is held in a queue entry and then in the result
// register. The sync byte register may be written only while no item is in
// flight.
module home_control_response_parser import hcrp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte [7:0], expect_kind [10:8], zero pad
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // status_value [7:0], report_value [15:8]
	output logic [3:0]  m_tuser,   // status_valid [0], report_kind [3:1]
	output logic        m_tlast,   // command_complete
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // sync_byte
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	qhs_t  pop_hs;
	logic  pop_ready;
	item_t pop_item;

	hcrp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.q_ready  (push_ready),
		.q_valid  (push_valid),
		.q_item   (push_item)
	);

	hcrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_hs_o  (pop_hs),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	hcrp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_hs    (pop_hs),
		.q_ready (pop_ready),
		.q_item  (pop_item),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
